// ===== rtl/gbfd_pkg.sv =====
// Package for the binary frame deframer.
// Holds field widths, sync codes and parameter defaults; depends on nothing.
package gbfd_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDX_W  = 6;

  localparam logic [DATA_W-1:0] SYNC_FIRST  = 8'hD0;
  localparam logic [DATA_W-1:0] SYNC_SECOND = 8'hDD;

  localparam int unsigned FRAME_LEN_DEF   = 35;
  localparam int unsigned CHECKED_LEN_DEF = 33;

endpackage

// ===== rtl/gbfd_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; used by the deframer for its frame store.
module gbfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 35
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gps_binary_frame_deframer.sv =====
// Top level of the binary frame deframer: sync hunt, checksum and replay control.
// Depends on gbfd_pkg and gbfd_ram.
//
// The block takes one received byte per item and hunts for the sync pair 0xD0, 0xDD.
// It then stores FRAME_LEN frame bytes in a RAM while it runs an 8-bit Fletcher sum
// over the first CHECKED_LEN of them; the next two bytes are the expected sums.
// While hunting and collecting, a byte is accepted every cycle. After the last
// frame byte the input is stalled: the sums are compared, then a matching frame is
// replayed from the RAM, each payload byte read from the RAM and then loaded
// into the output register; a read waits while the output is stalled. A mismatch
// gives one error item instead. The last item of a frame may still wait in the
// output register while the next frame is being collected.
module gps_binary_frame_deframer #(
  parameter int unsigned FRAME_LEN   = gbfd_pkg::FRAME_LEN_DEF,
  parameter int unsigned CHECKED_LEN = gbfd_pkg::CHECKED_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gbfd_pkg::DATA_W-1:0]  rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gbfd_pkg::DATA_W-1:0]  payload_byte_o,
  output logic [gbfd_pkg::IDX_W-1:0]   byte_index_o,
  output logic                         frame_ok_o,
  output logic                         last_o
);

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam logic [AW-1:0] CNT_EXP_A = AW'(CHECKED_LEN);
  localparam logic [AW-1:0] CNT_EXP_B = AW'(CHECKED_LEN + 1);
  localparam logic [AW-1:0] CNT_LAST  = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] IDX_LAST  = AW'(CHECKED_LEN - 1);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC1,
    ST_BODY,
    ST_CHECK,
    ST_REP_RD,
    ST_REP_LD
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               cnt_q;
  logic [AW-1:0]               rd_idx_q;
  logic [gbfd_pkg::DATA_W-1:0] sum_a_q, sum_b_q, exp_a_q, exp_b_q;
  logic [gbfd_pkg::DATA_W-1:0] sum_a_d;
  logic                        out_valid_q, frame_ok_q, last_q;
  logic [gbfd_pkg::DATA_W-1:0] payload_q;
  logic [gbfd_pkg::IDX_W-1:0]  index_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        sums_match;
  logic                        out_load;
  logic                        ram_we;
  logic [gbfd_pkg::DATA_W-1:0] ram_rdata;

  assign in_stall_o = !(state_q == ST_HUNT || state_q == ST_SYNC1 || state_q == ST_BODY);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sums_match = (sum_a_q == exp_a_q) && (sum_b_q == exp_b_q);
  assign out_load   = (state_q == ST_REP_LD) || (state_q == ST_CHECK && !sums_match && out_free);
  assign ram_we     = in_acc && (state_q == ST_BODY);
  assign sum_a_d    = sum_a_q + rx_byte_i;

  gbfd_ram #(
    .WIDTH (gbfd_pkg::DATA_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (rx_byte_i),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      exp_a_q     <= '0;
      exp_b_q     <= '0;
      out_valid_q <= 1'b0;
      frame_ok_q  <= 1'b0;
      last_q      <= 1'b0;
      payload_q   <= '0;
      index_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_HUNT: begin
          sum_a_q <= '0;
          sum_b_q <= '0;
          cnt_q   <= '0;
          if (in_acc && rx_byte_i == gbfd_pkg::SYNC_FIRST) begin
            state_q <= ST_SYNC1;
          end
        end
        ST_SYNC1: begin
          if (in_acc) begin
            state_q <= (rx_byte_i == gbfd_pkg::SYNC_SECOND) ? ST_BODY : ST_HUNT;
          end
        end
        ST_BODY: begin
          if (in_acc) begin
            if (cnt_q < CNT_EXP_A) begin
              sum_a_q <= sum_a_d;
              sum_b_q <= sum_b_q + sum_a_d;
            end
            if (cnt_q == CNT_EXP_A) begin
              exp_a_q <= rx_byte_i;
            end
            if (cnt_q == CNT_EXP_B) begin
              exp_b_q <= rx_byte_i;
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_LAST) begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          rd_idx_q <= '0;
          if (sums_match) begin
            state_q <= ST_REP_RD;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            payload_q   <= '0;
            index_q     <= '0;
            frame_ok_q  <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= ST_HUNT;
          end
        end
        ST_REP_RD: begin
          if (out_free) begin
            state_q <= ST_REP_LD;
          end
        end
        ST_REP_LD: begin
          out_valid_q <= 1'b1;
          payload_q   <= ram_rdata;
          index_q     <= gbfd_pkg::IDX_W'(rd_idx_q);
          frame_ok_q  <= 1'b1;
          last_q      <= (rd_idx_q == IDX_LAST);
          rd_idx_q    <= rd_idx_q + 1'b1;
          state_q     <= (rd_idx_q == IDX_LAST) ? ST_HUNT : ST_REP_RD;
        end
        default: begin
          state_q <= ST_HUNT;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_q;
  assign byte_index_o   = index_q;
  assign frame_ok_o     = frame_ok_q;
  assign last_o         = last_q;

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REP_LD |-> !out_valid_q)
    else $error("Replay load with the output register occupied.");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REP_LD |=> out_valid_o && frame_ok_o)
    else $error("Replay load did not present a payload item.");

  a_error_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_ok_o |-> payload_byte_o == '0 && byte_index_o == '0 && last_o)
    else $error("Malformed checksum error item.");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o && last_o |-> byte_index_o == gbfd_pkg::IDX_W'(CHECKED_LEN - 1))
    else $error("Last payload item at the wrong index.");

  a_no_input_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REP_RD || state_q == ST_REP_LD) |=> $stable(cnt_q))
    else $error("Frame count moved during replay.");

endmodule
